>>> src/msl_pkg.sv
package msl_pkg;

  localparam int COORD_BITS_DEF    = 6;
  localparam int STACK_ENTRIES_DEF = 8;

  // Points per request never exceed this; subdivision ends once it is reached
  localparam int RESULT_LIMIT = 64;
  localparam int LIMIT_BITS   = $clog2(RESULT_LIMIT + 1);

  typedef struct packed {
    logic busy;
    logic pend_valid;
  } msl_status_t;

endpackage

>>> src/msl_if.sv
interface msl_req_if
  import msl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  input ready);
  modport sink (input valid, input start_x, input start_y, input end_x, input end_y,
                output ready);
endinterface

interface msl_pt_if
  import msl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

>>> src/msl_front.sv
module msl_front
  import msl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic                    q_full,
  output logic                    q_push,
  output logic [4*COORD_BITS-1:0] q_data
);

  logic [COORD_BITS-1:0] span_x;
  logic [COORD_BITS-1:0] span_y;
  logic                  splittable;

  assign span_x = (in_start_x > in_end_x) ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
  assign span_y = (in_start_y > in_end_y) ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
  assign splittable = (span_x > COORD_BITS'(1)) && (span_y > COORD_BITS'(1));

  assign in_ready = !q_full;
  // drop requests that yield no points
  assign q_push   = in_valid && !q_full && splittable;
  assign q_data   = {in_start_x, in_start_y, in_end_x, in_end_y};

endmodule

>>> src/msl_req_fifo.sv
module msl_req_fifo
  import msl_pkg::*;
#(
  parameter int WIDTH = 4 * COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             wptr_nxt;
  logic             rptr_r;
  logic             rptr_nxt;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? !wptr_r : wptr_r;
    rptr_nxt = do_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> src/msl_back.sv
module msl_back
  import msl_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int STACK_ENTRIES = STACK_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  logic [4*COORD_BITS-1:0] q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_point_x,
  output logic [COORD_BITS-1:0]   out_point_y,
  output logic                    out_last_point,
  output msl_status_t             status
);

  localparam int LVL_W = $clog2(STACK_ENTRIES + 1);
  localparam int IDX_W = $clog2(STACK_ENTRIES);
  localparam int SEG_W = 4 * COORD_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [LVL_W-1:0]      lvl_r;
  logic [LVL_W-1:0]      lvl_nxt;
  logic                  cur_valid_r;
  logic                  cur_valid_nxt;
  logic [SEG_W-1:0]      cur_r;
  logic [SEG_W-1:0]      cur_nxt;
  logic [LIMIT_BITS-1:0] cnt_r;
  logic [LIMIT_BITS-1:0] cnt_nxt;
  logic                  pend_valid_r;
  logic                  pend_valid_nxt;
  logic [COORD_BITS-1:0] pend_x_r;
  logic [COORD_BITS-1:0] pend_y_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic                  out_last_r;
  logic [SEG_W-1:0]      stack_r [STACK_ENTRIES];

  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [COORD_BITS-1:0] bx;
  logic [COORD_BITS-1:0] by;
  logic [COORD_BITS-1:0] span_x;
  logic [COORD_BITS-1:0] span_y;
  logic                  split;
  logic [COORD_BITS:0]   sum_x;
  logic [COORD_BITS:0]   sum_y;
  logic [COORD_BITS-1:0] mx;
  logic [COORD_BITS-1:0] my;
  logic [LVL_W-1:0]      lvl_plus;
  logic [LVL_W-1:0]      lvl_minus;
  logic                  right_ok;
  logic                  left_ok;
  logic                  out_free;
  logic                  can_emit;
  logic                  pend_load;
  logic                  out_load;
  logic                  out_load_last;
  logic                  push_right;

  assign {ax, ay, bx, by} = cur_r;

  assign span_x = (ax > bx) ? (ax - bx) : (bx - ax);
  assign span_y = (ay > by) ? (ay - by) : (by - ay);
  assign split  = (span_x > COORD_BITS'(1)) && (span_y > COORD_BITS'(1));
  assign sum_x  = {1'b0, ax} + {1'b0, bx};
  assign sum_y  = {1'b0, ay} + {1'b0, by};
  assign mx     = sum_x[COORD_BITS:1];
  assign my     = sum_y[COORD_BITS:1];

  assign lvl_plus  = lvl_r + LVL_W'(1);
  assign lvl_minus = lvl_r - LVL_W'(1);
  assign right_ok  = lvl_r < LVL_W'(STACK_ENTRIES);
  assign left_ok   = right_ok && (lvl_plus < LVL_W'(STACK_ENTRIES));

  assign out_free = !out_valid_r || out_ready;
  assign can_emit = !pend_valid_r || out_free;

  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    cur_valid_nxt  = cur_valid_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_load      = 1'b0;
    out_load       = 1'b0;
    out_load_last  = 1'b0;
    push_right     = 1'b0;
    q_pop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          cur_nxt       = q_data;
          cur_valid_nxt = 1'b1;
          lvl_nxt       = '0;
          cnt_nxt       = '0;
          state_nxt     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cur_valid_r) begin
          if (!split) begin
            cur_valid_nxt = 1'b0;
          end else if (can_emit) begin
            // older point goes out unflagged, midpoint waits for its successor
            out_load       = pend_valid_r;
            pend_load      = 1'b1;
            pend_valid_nxt = 1'b1;
            cnt_nxt        = cnt_r + LIMIT_BITS'(1);
            push_right     = right_ok;
            if (cnt_r == LIMIT_BITS'(RESULT_LIMIT - 1)) begin
              cur_valid_nxt = 1'b0;
              lvl_nxt       = '0;
              state_nxt     = ST_FLUSH;
            end else begin
              lvl_nxt       = right_ok ? lvl_plus : lvl_r;
              cur_nxt       = {ax, ay, mx, my};
              cur_valid_nxt = left_ok;
            end
          end
        end else if (lvl_r != '0) begin
          cur_nxt       = stack_r[lvl_minus[IDX_W-1:0]];
          cur_valid_nxt = 1'b1;
          lvl_nxt       = lvl_minus;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_load_last  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lvl_r        <= '0;
      cur_valid_r  <= 1'b0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lvl_r        <= lvl_nxt;
      cur_valid_r  <= cur_valid_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (pend_load) begin
      pend_x_r <= mx;
      pend_y_r <= my;
    end
    if (out_load) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_last_r <= out_load_last;
    end
    if (push_right) begin
      stack_r[lvl_r[IDX_W-1:0]] <= {mx, my, bx, by};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_last_point = out_last_r;

  assign status.busy       = (state_r != ST_IDLE);
  assign status.pend_valid = pend_valid_r;

endmodule

>>> src/midpoint_subdivision_line_top.sv
// Channel  Dir  Payload                              Notes
// in_ch    in   start_x, start_y, end_x, end_y       one line request per item
// out_ch   out  point_x, point_y, last_point         one item per plotted point
//
// A request with a splittable span is worked by the single subdivision engine, one step
// per emitted point, per unsplit segment and per stack pop, with start and flush steps
// around them. Requests that yield no points are dropped on acceptance; two can wait queued.
// Synchronous active-low reset empties the queue and the stack and idles the engine.
// A stalled out_ch holds the engine once its one pending point cannot move on.
module midpoint_subdivision_line_top
  import msl_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int STACK_ENTRIES = STACK_ENTRIES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  msl_req_if.sink in_ch,
  msl_pt_if.source out_ch
);

  localparam int SEG_W = 4 * COORD_BITS;

  logic             q_push;
  logic [SEG_W-1:0] q_push_data;
  logic             q_pop;
  logic [SEG_W-1:0] q_pop_data;
  logic             q_full;
  logic             q_empty;
  msl_status_t      status;

  msl_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_start_x (in_ch.start_x),
    .in_start_y (in_ch.start_y),
    .in_end_x   (in_ch.end_x),
    .in_end_y   (in_ch.end_y),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  msl_req_fifo #(
    .WIDTH (SEG_W)
  ) u_req_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  msl_back #(
    .COORD_BITS    (COORD_BITS),
    .STACK_ENTRIES (STACK_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_pop_data),
    .q_pop          (q_pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_point_x    (out_ch.point_x),
    .out_point_y    (out_ch.point_y),
    .out_last_point (out_ch.last_point),
    .status         (status)
  );

`ifndef NO_ASSERTIONS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !status.busy |-> !status.pend_valid)
    else $error("idle engine still holds a point");

  a_start_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.busy) |-> $past(q_pop && !q_empty))
    else $error("engine started without a queued request");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("request queue both full and empty");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> status.busy)
    else $error("queue pop did not start the engine");
`endif

endmodule

>>> verif/line_point_checker.sv
`timescale 1ns / 100ps

module line_point_checker
  import msl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  msl_req_if   req,
  msl_pt_if    pt,
  output int   fail_count,
  output int   points_pending
);

  typedef logic [COORD_BITS_DEF-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } segment_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last_point;
  } point_t;

  point_t expected_points[$];
  int     mismatches = 0;

  assign fail_count = mismatches;

  task report(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic wide_span(input coord_t a, input coord_t b);
    coord_t diff;
    diff = (a > b) ? a - b : b - a;
    return diff > 1;
  endfunction

  // Pre-order subdivision: emit the midpoint, then work the left half before the right.
  function automatic void subdivide_line(input coord_t sx, sy, ex, ey);
    segment_t                  stack [STACK_ENTRIES_DEF];
    segment_t                  seg;
    int                        level;
    int                        count;
    logic [COORD_BITS_DEF:0]   sum_x;
    logic [COORD_BITS_DEF:0]   sum_y;
    coord_t                    mx;
    coord_t                    my;
    stack[0] = '{sx, sy, ex, ey};
    level    = 1;
    count    = 0;
    while (level > 0 && count < RESULT_LIMIT) begin
      level--;
      seg = stack[level];
      if (wide_span(seg.ax, seg.bx) && wide_span(seg.ay, seg.by)) begin
        sum_x = {1'b0, seg.ax} + {1'b0, seg.bx};
        sum_y = {1'b0, seg.ay} + {1'b0, seg.by};
        mx    = sum_x[COORD_BITS_DEF:1];
        my    = sum_y[COORD_BITS_DEF:1];
        expected_points.push_back('{mx, my, 1'b0});
        count++;
        // drop a push onto a full stack
        if (level < STACK_ENTRIES_DEF) begin
          stack[level] = '{mx, my, seg.bx, seg.by};
          level++;
        end
        if (level < STACK_ENTRIES_DEF) begin
          stack[level] = '{seg.ax, seg.ay, mx, my};
          level++;
        end
      end
    end
    if (count > 0)
      expected_points[expected_points.size()-1].last_point = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    point_t want;
    if (rst_n) begin
      // points on the output belong to requests taken at earlier edges: pop before push
      if (pt.valid && pt.ready) begin
        if (expected_points.size() == 0) begin
          report($sformatf("unexpected point (%0d,%0d) last_point=%0d",
                           pt.point_x, pt.point_y, pt.last_point));
        end else begin
          want = expected_points.pop_front();
          if (pt.point_x !== want.x)
            report($sformatf("point_x got %0d want %0d", pt.point_x, want.x));
          if (pt.point_y !== want.y)
            report($sformatf("point_y got %0d want %0d", pt.point_y, want.y));
          if (pt.last_point !== want.last_point)
            report($sformatf("last_point got %0d want %0d at (%0d,%0d)",
                             pt.last_point, want.last_point, want.x, want.y));
        end
      end
      if (req.valid && req.ready)
        subdivide_line(req.start_x, req.start_y, req.end_x, req.end_y);
    end
    points_pending <= expected_points.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import msl_pkg::*;

  typedef logic [COORD_BITS_DEF-1:0] coord_t;

  localparam int COORD_MAX      = (1 << COORD_BITS_DEF) - 1;
  localparam int RANDOM_ITEMS   = 280;
  localparam int CALM_ITEMS     = 40;
  localparam int STALL_AFTER    = 40;
  localparam int STALL_CYCLES   = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  int   sent_count = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   points_pending;

  msl_req_if in_ch ();
  msl_pt_if  out_ch ();

  midpoint_subdivision_line_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  line_point_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (in_ch),
    .pt             (out_ch),
    .fail_count     (fail_count),
    .points_pending (points_pending)
  );

  always #6 clk = ~clk;

  function automatic coord_t clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  task automatic send_line(input coord_t sx, sy, ex, ey);
    in_ch.valid   <= 1'b1;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // request source
  initial begin
    int     shape;
    coord_t sx, sy, ex, ey;
    in_ch.valid   <= 1'b0;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;
    rst_n         <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, diagonals and lines too thin to split
    send_line(0, 0, 63, 63);
    send_line(63, 63, 0, 0);
    send_line(0, 63, 63, 0);
    send_line(63, 0, 0, 63);
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    send_line(0, 0, 1, 63);
    send_line(0, 0, 63, 1);
    send_line(20, 5, 21, 60);
    send_line(31, 32, 32, 31);
    send_line(0, 0, 2, 2);
    send_line(2, 2, 0, 0);
    send_line(0, 0, 3, 3);
    send_line(10, 10, 12, 50);
    send_line(0, 0, 63, 2);
    send_line(5, 40, 60, 43);
    send_line(17, 3, 3, 17);
    send_line(42, 42, 42, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm  = (i >= RANDOM_ITEMS - CALM_ITEMS);
      shape = $urandom_range(0, 9);
      sx    = coord_t'($urandom_range(0, COORD_MAX));
      sy    = coord_t'($urandom_range(0, COORD_MAX));
      ex    = coord_t'($urandom_range(0, COORD_MAX));
      ey    = coord_t'($urandom_range(0, COORD_MAX));
      if (shape == 6 || shape == 7) begin
        // one span of at most 1: no points
        if ($urandom_range(0, 1) == 0)
          ex = clamp_coord(int'(sx) + int'($urandom_range(0, 2)) - 1);
        else
          ey = clamp_coord(int'(sy) + int'($urandom_range(0, 2)) - 1);
      end else if (shape >= 8) begin
        ex = clamp_coord(int'(sx) + int'($urandom_range(0, 12)) - 6);
        ey = clamp_coord(int'(sy) + int'($urandom_range(0, 12)) - 6);
      end
      send_line(sx, sy, ex, ey);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // point sink
  initial begin
    bit stalled;
    stalled = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!stalled && sent_count >= STALL_AFTER) begin
        // hold off long enough for the request queue to back up
        stalled = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
